// ----- rtl/core/ikc_pkg.sv -----
`default_nettype none

package ikc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int KMAX        = 5;
  localparam int PIXEL_BITS  = 16;
  localparam int COEF_BITS   = 16;
  localparam int VALUE_BITS  = 32;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_RESULTS = 9;

  // input command codes
  localparam logic CMD_COEF  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_COLS  = 3'd2,
    CFG_KERNEL_ROWS  = 3'd3,
    CFG_FRAC_SHIFT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_TAP,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                        command;
    logic [4:0]                  coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic signed [PIXEL_BITS-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [9:0]                   out_col;
    logic [11:0]                  out_row;
    logic                         last;
    logic                         image_done;
    logic                         bad_kernel;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic tap;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic bad;
    logic skip;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
    logic res_done;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/image_kernel_smoothing_core.sv -----
// Channel  Direction  Handshake                 Word
// in       in         in_valid_i / in_ready_o   in_word_i   (coefficient or pixel)
// out      out        out_valid_o / out_ready_i out_word_o  (smoothed pixel)
// cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A coefficient word is taken and then prepared. A pixel word is taken and prepared,
// then for each result it streams kernel_rows * kernel_cols taps, drains the
// multiply-accumulate pipeline and emits: one shared multiply-accumulate handles one kernel
// tap a cycle. A pixel under a bad kernel size is taken, prepared and emitted; a
// pixel that completes no window is only taken and prepared.
// Reset clears the kernel table, position and control; the row store is not
// cleared. A stalled result word waits in the output register; the next input
// word is taken meanwhile and work halts only when a new result must be loaded.
`default_nettype none

module image_kernel_smoothing_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ikc_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ikc_pkg::out_word_t     out_word_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [12:0]       cfg_data_i
);

  ikc_pkg::ctrl_cmd_t    cmd;
  ikc_pkg::ctrl_status_t st;

  // configuration writes go straight into the registers, always taken
  assign cfg_ready_o = 1'b1;

  // sequence: take word, prepare window, stream taps, drain, emit result
  ikc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // row store, kernel table, address generation and multiply-accumulate
  ikc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ikc_ram.sv -----
`default_nettype none

module ikc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5120
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ikc_ctrl.sv -----
`default_nettype none

module ikc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ikc_pkg::ctrl_status_t st_i,
  output ikc_pkg::ctrl_cmd_t         cmd_o
);

  ikc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ikc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ikc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ikc_pkg::ST_PREP;
        end
      end
      ikc_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        priority if (!st_i.is_pixel) state_d = ikc_pkg::ST_IDLE;
        else if (st_i.bad)           state_d = ikc_pkg::ST_EMIT;
        else if (st_i.skip)          state_d = ikc_pkg::ST_IDLE;
        else                         state_d = ikc_pkg::ST_TAP;
      end
      ikc_pkg::ST_TAP: begin
        cmd_o.tap = 1'b1;
        if (st_i.tap_last) state_d = ikc_pkg::ST_DRAIN;
      end
      ikc_pkg::ST_DRAIN: begin
        if (!st_i.pipe_busy) state_d = ikc_pkg::ST_EMIT;
      end
      ikc_pkg::ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = st_i.res_done ? ikc_pkg::ST_IDLE : ikc_pkg::ST_TAP;
        end
      end
      default: state_d = ikc_pkg::ST_IDLE;
    endcase
  end

  a_take_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ikc_pkg::ST_PREP)
    else $error("accepted word did not move to prep");

  a_drain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ikc_pkg::ST_DRAIN && st_i.pipe_busy |=> state_q == ikc_pkg::ST_DRAIN)
    else $error("drain left with products in flight");

endmodule

`default_nettype wire

// ----- rtl/core/ikc_dpath.sv -----
`default_nettype none

module ikc_dpath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ikc_pkg::in_word_t     in_word_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [12:0]           cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ikc_pkg::out_word_t         out_word_o,
  input  wire ikc_pkg::ctrl_cmd_t    cmd_i,
  output ikc_pkg::ctrl_status_t      st_o
);

  localparam int MAX_WIDTH = ikc_pkg::MAX_WIDTH;
  localparam int KMAX      = ikc_pkg::KMAX;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = CW + 1;
  localparam int CSW  = CW + 2;
  localparam int RSW  = 14;
  localparam int SW   = $clog2(KMAX);
  localparam int KW   = $clog2(KMAX);
  localparam int KN   = KMAX * KMAX;
  localparam int KIW  = $clog2(KN);
  localparam int AW   = $clog2(KMAX * MAX_WIDTH);
  localparam int CMPW = (WW > 11) ? WW : 11;
  localparam int PW   = ikc_pkg::PIXEL_BITS + ikc_pkg::COEF_BITS;
  localparam int ACCW = PW + $clog2(KN);

  // configuration registers
  logic [10:0] cfg_width_q;
  logic [12:0] cfg_height_q;
  logic [2:0]  cfg_kcols_q, cfg_krows_q;
  logic [4:0]  cfg_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= 11'd1024;
      cfg_height_q <= 13'd1024;
      cfg_kcols_q  <= 3'd3;
      cfg_krows_q  <= 3'd3;
      cfg_shift_q  <= 5'd15;
    end else if (cfg_valid_i) begin
      unique case (ikc_pkg::cfg_reg_e'(cfg_index_i))
        ikc_pkg::CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i[10:0];
        ikc_pkg::CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        ikc_pkg::CFG_KERNEL_COLS:  cfg_kcols_q  <= cfg_data_i[2:0];
        ikc_pkg::CFG_KERNEL_ROWS:  cfg_krows_q  <= cfg_data_i[2:0];
        ikc_pkg::CFG_FRAC_SHIFT:   cfg_shift_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(KMAX - 1)) ? '0 : s + SW'(1);
  endfunction

  ikc_pkg::in_word_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_word_i;
  end

  // kernel table, cleared at reset
  logic signed [ikc_pkg::COEF_BITS-1:0] ktab_q [KN];
  logic coef_we;
  assign coef_we = cmd_i.prep && item_q.command == ikc_pkg::CMD_COEF &&
                   32'(item_q.coef_index) < 32'(KN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KN; i++) ktab_q[i] <= '0;
    end else if (coef_we) begin
      ktab_q[KIW'(item_q.coef_index)] <= item_q.coef_value;
    end
  end

  // effective sizes and pixel position
  logic [CMPW-1:0] w_ext;
  logic [WW-1:0]   w_eff;
  logic [12:0]     h_eff;
  logic [CW-1:0]   in_col_q;
  logic [11:0]     in_row_q;
  logic [SW-1:0]   slot_q;
  logic [WW-1:0]   col_a, col_n;
  logic [12:0]     row_a, row_n;
  logic [SW-1:0]   slot_a, slot_n;

  always_comb begin
    w_ext = CMPW'(cfg_width_q);
    if (w_ext == '0)                     w_eff = WW'(1);
    else if (w_ext > CMPW'(MAX_WIDTH))   w_eff = WW'(MAX_WIDTH);
    else                                 w_eff = WW'(w_ext);
    if (cfg_height_q == '0)                           h_eff = 13'd1;
    else if (cfg_height_q > 13'(ikc_pkg::MAX_HEIGHT)) h_eff = 13'(ikc_pkg::MAX_HEIGHT);
    else                                              h_eff = cfg_height_q;

    col_a  = WW'(in_col_q);
    row_a  = {1'b0, in_row_q};
    slot_a = slot_q;
    if (col_a >= w_eff) begin
      col_a  = '0;
      row_a  = row_a + 13'd1;
      slot_a = slot_inc(slot_a);
    end
    if (row_a >= h_eff) begin
      row_a  = '0;
      slot_a = '0;
    end

    col_n  = col_a + WW'(1);
    row_n  = row_a;
    slot_n = slot_a;
    if (col_n >= w_eff) begin
      col_n  = '0;
      row_n  = row_a + 13'd1;
      slot_n = slot_inc(slot_a);
      if (row_n >= h_eff) begin
        row_n  = '0;
        slot_n = '0;
      end
    end
  end

  logic pix_prep;
  assign pix_prep = cmd_i.prep && item_q.command == ikc_pkg::CMD_PIXEL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      slot_q   <= '0;
    end else if (pix_prep) begin
      in_col_q <= col_n[CW-1:0];
      in_row_q <= row_n[11:0];
      slot_q   <= slot_n;
    end
  end

  // window bounds
  logic                  bad_c, skip_c;
  logic [1:0]            hr, hc;
  logic signed [RSW-1:0] pr_s, hs, r0_c, r1_c, rt;
  logic signed [CSW-1:0] pc_s, ws, c0_c, c1_c, ct;

  always_comb begin
    bad_c = !cfg_kcols_q[0] || !cfg_krows_q[0] ||
            4'(cfg_kcols_q) > 4'(KMAX) || 4'(cfg_krows_q) > 4'(KMAX);
    hr   = cfg_krows_q[2:1];
    hc   = cfg_kcols_q[2:1];
    pr_s = $signed(RSW'(row_a));
    pc_s = $signed(CSW'(col_a));
    hs   = $signed(RSW'(h_eff));
    ws   = $signed(CSW'(w_eff));
    rt   = hs - RSW'(1) - $signed(RSW'(hr));
    ct   = ws - CSW'(1) - $signed(CSW'(hc));
    if (pr_s == hs - RSW'(1)) begin
      r0_c = (rt < 0) ? '0 : rt;
      r1_c = hs - RSW'(1);
    end else begin
      r0_c = pr_s - $signed(RSW'(hr));
      r1_c = r0_c;
    end
    if (pc_s == ws - CSW'(1)) begin
      c0_c = (ct < 0) ? '0 : ct;
      c1_c = ws - CSW'(1);
    end else begin
      c0_c = pc_s - $signed(CSW'(hc));
      c1_c = c0_c;
    end
    skip_c = r0_c < 0 || c0_c < 0;
  end

  // result and tap sequencing registers
  logic signed [RSW-1:0] res_r_q, r1_q, pr_q, h_q;
  logic signed [CSW-1:0] res_c_q, c0_q, c1_q, w_q;
  logic [1:0]            hr_q, hc_q;
  logic [SW-1:0]         slot_p_q;
  logic                  bad_q;
  logic [3:0]            nres_q;
  logic [KW-1:0]         ky_q, kx_q;
  logic                  kx_last, tap_last, res_last;

  assign kx_last  = 4'(kx_q) == 4'(cfg_kcols_q) - 4'd1;
  assign tap_last = kx_last && 4'(ky_q) == 4'(cfg_krows_q) - 4'd1;
  assign res_last = (res_r_q == r1_q && res_c_q == c1_q) ||
                    nres_q == 4'(ikc_pkg::MAX_RESULTS - 1);

  always_ff @(posedge clk_i) begin
    if (pix_prep) begin
      res_r_q  <= bad_c ? pr_s : r0_c;
      res_c_q  <= bad_c ? pc_s : c0_c;
      r1_q     <= r1_c;
      c0_q     <= c0_c;
      c1_q     <= c1_c;
      pr_q     <= pr_s;
      h_q      <= hs;
      w_q      <= ws;
      hr_q     <= hr;
      hc_q     <= hc;
      slot_p_q <= slot_a;
      bad_q    <= bad_c;
      nres_q   <= '0;
      ky_q     <= '0;
      kx_q     <= '0;
    end else if (cmd_i.tap) begin
      if (kx_last) begin
        kx_q <= '0;
        ky_q <= ky_q + KW'(1);
      end else begin
        kx_q <= kx_q + KW'(1);
      end
    end else if (cmd_i.emit) begin
      ky_q   <= '0;
      kx_q   <= '0;
      nres_q <= nres_q + 4'd1;
      if (res_c_q == c1_q) begin
        res_c_q <= c0_q;
        res_r_q <= res_r_q + RSW'(1);
      end else begin
        res_c_q <= res_c_q + CSW'(1);
      end
    end
  end

  // tap address generation
  logic signed [RSW-1:0] rr, row_back;
  logic signed [CSW-1:0] cc;
  logic                  tap_ok;
  logic [SW-1:0]         dd, slot_t;
  logic [SW:0]           slot_w;
  logic [AW-1:0]         raddr, waddr;
  logic [KIW-1:0]        kidx;

  always_comb begin
    rr       = res_r_q - $signed(RSW'(hr_q)) + $signed(RSW'(ky_q));
    cc       = res_c_q - $signed(CSW'(hc_q)) + $signed(CSW'(kx_q));
    tap_ok   = rr >= 0 && rr < h_q && cc >= 0 && cc < w_q;
    row_back = pr_q - rr;
    dd       = row_back[SW-1:0];
    slot_w = (slot_p_q >= dd) ? {1'b0, slot_p_q} - {1'b0, dd}
                              : {1'b0, slot_p_q} + (SW+1)'(KMAX) - {1'b0, dd};
    slot_t = slot_w[SW-1:0];
    raddr  = AW'(slot_t) * AW'(MAX_WIDTH) + AW'(cc[CW-1:0]);
    waddr  = AW'(slot_a) * AW'(MAX_WIDTH) + AW'(col_a[CW-1:0]);
    kidx   = KIW'(ky_q) * KIW'(KMAX) + KIW'(kx_q);
  end

  logic [ikc_pkg::PIXEL_BITS-1:0] rdata;

  ikc_ram #(
    .WIDTH (ikc_pkg::PIXEL_BITS),
    .DEPTH (KMAX * MAX_WIDTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (pix_prep),
    .waddr_i (waddr),
    .wdata_i (item_q.pixel),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // multiply-accumulate pipeline
  logic                                 s1_v_q, s2_v_q;
  logic signed [ikc_pkg::COEF_BITS-1:0] s1_coef_q;
  logic signed [PW-1:0]                 s2_prod_q;
  logic signed [ACCW-1:0]               acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.tap && tap_ok;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_coef_q <= ktab_q[kidx];
    s2_prod_q <= $signed(rdata) * s1_coef_q;
    if (cmd_i.prep || cmd_i.emit) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + ACCW'(s2_prod_q);
    end
  end

  // shift, saturate and hold the result word
  logic signed [ACCW-1:0] shifted;
  logic [31:0]            sat;

  always_comb begin
    shifted = acc_q >>> cfg_shift_q;
    if (&shifted[ACCW-1:31] || ~|shifted[ACCW-1:31]) sat = shifted[31:0];
    else if (shifted[ACCW-1])                         sat = 32'h8000_0000;
    else                                              sat = 32'h7FFF_FFFF;
  end

  logic out_valid_q;
  ikc_pkg::out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.value      <= bad_q ? '0 : $signed(sat);
      out_q.out_col    <= 10'($unsigned(res_c_q));
      out_q.out_row    <= res_r_q[11:0];
      out_q.last       <= bad_q || res_last;
      out_q.image_done <= res_r_q == h_q - RSW'(1) && res_c_q == w_q - CSW'(1);
      out_q.bad_kernel <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    st_o           = '0;
    st_o.is_pixel  = item_q.command == ikc_pkg::CMD_PIXEL;
    st_o.bad       = bad_c;
    st_o.skip      = skip_c;
    st_o.tap_last  = tap_last;
    st_o.pipe_busy = s1_v_q || s2_v_q;
    st_o.out_free  = !out_valid_q || out_ready_i;
    st_o.res_done  = bad_q || res_last;
  end

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bad_kernel |-> out_q.last && out_q.value == '0)
    else $error("bad kernel word not final or not zero");

  a_no_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !s1_v_q && !s2_v_q)
    else $error("result taken before accumulation finished");

endmodule

`default_nettype wire
